### hdl/footprint_tile_enumerator_macros.svh
// Assertion macros shared by the footprint tile enumerator RTL
// Expects clk_i and rst_ni in the scope where a macro is used
`ifndef FOOTPRINT_TILE_ENUMERATOR_MACROS_SVH
`define FOOTPRINT_TILE_ENUMERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define FTE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ftile_pkg.sv
// Shared constants, codes and width helpers of the footprint tile enumerator
// No dependencies
`timescale 1ns / 1ps

package ftile_pkg;

  // default values of the top-level parameters
  localparam int GRID_MAX_DEF  = 64;
  localparam int MAX_SPAN_DEF  = 8;
  localparam int FRAC_BITS_DEF = 8;

  // fixed field widths
  localparam int ID_W    = 16;
  localparam int COORD_W = 16;
  localparam int TILE_W  = 6;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // doubled coordinate plus extent plus rounding term, signed
  localparam int DBL_W = 19;

  // entries of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic {
    SHAPE_CIRCLE = 1'b0,
    SHAPE_RECT   = 1'b1
  } shape_e;

  // tile column/row index width inside the grid
  function automatic int coord_w(input int grid_max);
    return $clog2(grid_max);
  endfunction

  // width that holds a grid size up to grid_max
  function automatic int gcount_w(input int grid_max);
    return $clog2(grid_max + 1);
  endfunction

  // signed tile position width (bounding box before grid clipping)
  function automatic int tpos_w(input int grid_max, input int frac_bits);
    int a;
    int b;
    a = DBL_W - frac_bits;
    b = gcount_w(grid_max) + 2;
    return (a > b) ? a : b;
  endfunction

  // unsigned extent / distance magnitude width, doubled units
  function automatic int mag_w(input int frac_bits);
    return frac_bits + 3;
  endfunction

  // packed job word passed from front to back
  function automatic int job_width(input int grid_max, input int frac_bits);
    return 1 + ID_W + 2 * DBL_W + 4 * coord_w(grid_max) + 2 * tpos_w(grid_max, frac_bits)
           + 2 * mag_w(frac_bits);
  endfunction

endpackage

### hdl/ftile_if.sv
// Valid/ready channel interfaces for footprint words and tile words
// Depends on ftile_pkg
`timescale 1ns / 1ps

interface ftile_item_if;
  import ftile_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ID_W-1:0]           entity_id;
  logic                      shape_kind;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] size_x;
  logic signed [COORD_W-1:0] size_y;

  modport source (
    output valid, entity_id, shape_kind, center_x, center_y, size_x, size_y,
    input  ready
  );
  modport sink (
    input  valid, entity_id, shape_kind, center_x, center_y, size_x, size_y,
    output ready
  );
endinterface

interface ftile_tile_if;
  import ftile_pkg::*;

  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] tile_x;
  logic [TILE_W-1:0] tile_y;
  logic [ID_W-1:0]   owner_id;
  logic              in_occupation;
  logic              in_center_grid;
  logic              last_tile;

  modport source (
    output valid, tile_x, tile_y, owner_id, in_occupation, in_center_grid, last_tile,
    input  ready
  );
  modport sink (
    input  valid, tile_x, tile_y, owner_id, in_occupation, in_center_grid, last_tile,
    output ready
  );
endinterface

### hdl/footprint_tile_enumerator.sv
// Footprint tile enumerator: circle or rectangle footprint in, touched tiles out.
// Channels: item_i takes one footprint word (valid/ready); tile_o gives one word
// per touched in-grid tile, in row order, last_tile set on the final one.
// An item whose box misses the grid, or an empty grid, gives no word at all.
// Configuration: cfg_we_i writes grid_width (index 0) or grid_height (index 1);
// write only while the block is idle.
// Throughput: the scanner tests one candidate tile per cycle unless stalled, so
// an item takes one test per in-grid tile in its span-limited bounding box,
// from 1 to MAX_SPAN*MAX_SPAN tests. The front end works on
// the next item meanwhile, with a two-entry job queue in between.
// Path: input register, job queue, test, held and output registers; each word
// waits for the next hit or the end of its box, so it knows if it is the last.
// Reset clears the grid size to zero and empties all stages.
// A stalled receiver holds tile_o steady and backs up into the scanner, queue
// and finally item_i.ready; nothing is dropped.
// Depends on ftile_pkg, ftile_if, ftile_front, ftile_queue and ftile_back
`timescale 1ns / 1ps

module footprint_tile_enumerator #(
  parameter int GRID_MAX  = ftile_pkg::GRID_MAX_DEF,
  parameter int MAX_SPAN  = ftile_pkg::MAX_SPAN_DEF,
  parameter int FRAC_BITS = ftile_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ftile_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ftile_pkg::CFG_W-1:0]     cfg_data_i,
  ftile_item_if.sink                      item_i,
  ftile_tile_if.source                    tile_o
);
  import ftile_pkg::*;

  localparam int JOB_W = job_width(GRID_MAX, FRAC_BITS);

  logic [CFG_W-1:0] grid_width_q, grid_width_d;
  logic [CFG_W-1:0] grid_height_q, grid_height_d;

  logic             fj_valid, fj_ready, bj_valid, bj_ready;
  logic [JOB_W-1:0] fj_data, bj_data;

  // configuration registers
  always_comb begin
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  grid_width_d  = cfg_data_i;
        CFG_GRID_HEIGHT: grid_height_d = cfg_data_i;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= '0;
      grid_height_q <= '0;
    end else begin
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
    end
  end

  // footprint setup
  ftile_front #(
    .GRID_MAX  (GRID_MAX),
    .MAX_SPAN  (MAX_SPAN),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .item_i        (item_i),
    .job_valid_o   (fj_valid),
    .job_ready_i   (fj_ready),
    .job_o         (fj_data)
  );

  // job queue
  ftile_queue #(
    .W     (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fj_valid),
    .in_ready_o  (fj_ready),
    .in_data_i   (fj_data),
    .out_valid_o (bj_valid),
    .out_ready_i (bj_ready),
    .out_data_o  (bj_data)
  );

  // tile scanner
  ftile_back #(
    .GRID_MAX  (GRID_MAX),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bj_data),
    .tile_o      (tile_o)
  );

endmodule

### hdl/ftile_front.sv
// Front end: registers a footprint word, clamps its size, derives the clipped
// tile box, rounded center and squared radius, and pushes a job word.
// Depends on ftile_pkg and ftile_if
`timescale 1ns / 1ps

module ftile_front #(
  parameter int GRID_MAX  = ftile_pkg::GRID_MAX_DEF,
  parameter int MAX_SPAN  = ftile_pkg::MAX_SPAN_DEF,
  parameter int FRAC_BITS = ftile_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [ftile_pkg::CFG_W-1:0]           grid_width_i,
  input  logic [ftile_pkg::CFG_W-1:0]           grid_height_i,
  ftile_item_if.sink                            item_i,
  output logic                                  job_valid_o,
  input  logic                                  job_ready_i,
  output logic [ftile_pkg::job_width(GRID_MAX, FRAC_BITS)-1:0] job_o
);
  import ftile_pkg::*;

  localparam int CW   = coord_w(GRID_MAX);
  localparam int GW_W = gcount_w(GRID_MAX);
  localparam int TW   = tpos_w(GRID_MAX, FRAC_BITS);
  localparam int MW   = mag_w(FRAC_BITS);
  localparam int SH   = FRAC_BITS + 1;
  localparam int RECT_MAX = (MAX_SPAN - 2) << FRAC_BITS;
  localparam int RAD_MAX  = RECT_MAX / 2;
  localparam logic signed [DBL_W-1:0] ONE_D    = DBL_W'(1) << FRAC_BITS;
  localparam logic signed [DBL_W-1:0] ONE_M1_D = ONE_D - DBL_W'(1);
  localparam logic signed [TW-1:0]    SPAN_M1  = TW'(MAX_SPAN - 1);
  localparam logic [FRAC_BITS-1:0]    HALF     = FRAC_BITS'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic                    rect;
    logic [ID_W-1:0]         id;
    logic signed [DBL_W-1:0] c2x;
    logic signed [DBL_W-1:0] c2y;
    logic [CW-1:0]           xs;
    logic [CW-1:0]           xe;
    logic [CW-1:0]           ys;
    logic [CW-1:0]           ye;
    logic signed [TW-1:0]    rx;
    logic signed [TW-1:0]    ry;
    logic [2*MW-1:0]         r2;
  } job_t;

  // clamp a signed size to 0..lim
  function automatic logic [MW-1:0] clamp_size(input logic signed [COORD_W-1:0] s,
                                               input int lim);
    logic [MW-1:0] r;
    if (s < 0) begin
      r = '0;
    end else if (int'(s) > lim) begin
      r = MW'(lim);
    end else begin
      r = MW'(s);
    end
    return r;
  endfunction

  // round a Q center to the nearest tile, ties to even
  function automatic logic signed [TW-1:0] round_even(input logic signed [COORD_W-1:0] c);
    logic signed [TW-1:0] q;
    logic [FRAC_BITS-1:0] rem;
    q   = TW'(c >>> FRAC_BITS);
    rem = c[FRAC_BITS-1:0];
    if (rem > HALF || (rem == HALF && q[0])) begin
      q = q + TW'(1);
    end
    return q;
  endfunction

  logic                      iv_q, iv_d;
  logic [ID_W-1:0]           id_q;
  logic                      rect_q;
  logic signed [COORD_W-1:0] cx_q, cy_q, sx_q, sy_q;

  logic                    accept, drain, empty_box;
  logic [MW-1:0]           ex, ey, rad2;
  logic signed [DBL_W-1:0] c2x, c2y, exs, eys;
  logic signed [DBL_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [TW-1:0]    x0, x1, y0, y1, x1c, y1c;
  logic signed [TW-1:0]    xs_t, xe_t, ys_t, ye_t, gw_lim, gh_lim;
  logic [GW_W-1:0]         gwe, ghe;
  job_t                    job_d;

  // input stage handshake
  assign drain        = empty_box || job_ready_i;
  assign item_i.ready = !iv_q || drain;
  assign accept       = item_i.valid && item_i.ready;
  assign job_valid_o  = iv_q && !empty_box;

  always_comb begin
    iv_d = iv_q;
    if (accept) begin
      iv_d = 1'b1;
    end else if (drain) begin
      iv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else begin
      iv_q <= iv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q   <= item_i.entity_id;
      rect_q <= (item_i.shape_kind == SHAPE_RECT);
      cx_q   <= item_i.center_x;
      cy_q   <= item_i.center_y;
      sx_q   <= item_i.size_x;
      sy_q   <= item_i.size_y;
    end
  end

  // extents in doubled units: full size for rectangles, diameter for circles
  assign rad2 = MW'(clamp_size(sx_q, RAD_MAX) << 1);
  assign ex   = rect_q ? clamp_size(sx_q, RECT_MAX) : rad2;
  assign ey   = rect_q ? clamp_size(sy_q, RECT_MAX) : rad2;
  assign exs  = DBL_W'(ex);
  assign eys  = DBL_W'(ey);
  assign c2x  = DBL_W'(cx_q) <<< 1;
  assign c2y  = DBL_W'(cy_q) <<< 1;
  assign lo_x = c2x - exs;
  assign hi_x = c2x + exs;
  assign lo_y = c2y - eys;
  assign hi_y = c2y + eys;

  // tile bounding box: ceil on the low side, floor on the high side
  assign x0 = TW'((lo_x + ONE_M1_D) >>> SH);
  assign x1 = TW'((hi_x + ONE_D) >>> SH);
  assign y0 = TW'((lo_y + ONE_M1_D) >>> SH);
  assign y1 = TW'((hi_y + ONE_D) >>> SH);

  // span limit, then clip to the grid
  assign x1c = (x1 > x0 + SPAN_M1) ? x0 + SPAN_M1 : x1;
  assign y1c = (y1 > y0 + SPAN_M1) ? y0 + SPAN_M1 : y1;

  assign gwe    = (int'(grid_width_i) > GRID_MAX) ? GW_W'(GRID_MAX) : GW_W'(grid_width_i);
  assign ghe    = (int'(grid_height_i) > GRID_MAX) ? GW_W'(GRID_MAX) : GW_W'(grid_height_i);
  assign gw_lim = TW'(gwe) - TW'(1);
  assign gh_lim = TW'(ghe) - TW'(1);

  assign xs_t = (x0 < 0) ? '0 : x0;
  assign ys_t = (y0 < 0) ? '0 : y0;
  assign xe_t = (x1c > gw_lim) ? gw_lim : x1c;
  assign ye_t = (y1c > gh_lim) ? gh_lim : y1c;

  // an empty grid makes the limit negative, so it empties the box too
  assign empty_box = (xs_t > xe_t) || (ys_t > ye_t);

  // job word
  always_comb begin
    job_d.rect = rect_q;
    job_d.id   = id_q;
    job_d.c2x  = c2x;
    job_d.c2y  = c2y;
    job_d.xs   = CW'(xs_t);
    job_d.xe   = CW'(xe_t);
    job_d.ys   = CW'(ys_t);
    job_d.ye   = CW'(ye_t);
    job_d.rx   = round_even(cx_q);
    job_d.ry   = round_even(cy_q);
    job_d.r2   = (2 * MW)'(rad2) * (2 * MW)'(rad2);
  end

  assign job_o = job_d;

endmodule

### hdl/ftile_queue.sv
// Small register queue between the front end and the tile scanner
// Depends on ftile_pkg (queue depth default) and the assertion macro header
`timescale 1ns / 1ps
`include "footprint_tile_enumerator_macros.svh"

module ftile_queue #(
  parameter int W     = 8,
  parameter int DEPTH = ftile_pkg::QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]    PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != CNT_FULL);
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointers and fill count
  always_comb begin
    wp_d    = wp_q;
    rp_d    = rp_q;
    count_d = count_q;
    if (push) begin
      wp_d = (wp_q == PTR_LAST) ? '0 : wp_q + PW'(1);
    end
    if (pop) begin
      rp_d = (rp_q == PTR_LAST) ? '0 : rp_q + PW'(1);
    end
    case ({push, pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end

  `FTE_ASSERT_IMP(a_q_count_bound, 1'b1, count_q <= CNT_FULL, "queue count beyond depth")
  `FTE_ASSERT_NEXT(a_q_ptr_gap, count_q == '0 && !push, wp_q == rp_q, "queue pointers apart when empty")

endmodule

### hdl/ftile_back.sv
// Back end: scans one job's clipped tile box a tile per cycle unless stalled,
// tests circle distance, holds one hit back so the last one gets last_tile.
// Depends on ftile_pkg, ftile_if and the assertion macro header
`timescale 1ns / 1ps
`include "footprint_tile_enumerator_macros.svh"

module ftile_back #(
  parameter int GRID_MAX  = ftile_pkg::GRID_MAX_DEF,
  parameter int FRAC_BITS = ftile_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  job_valid_i,
  output logic                                  job_ready_o,
  input  logic [ftile_pkg::job_width(GRID_MAX, FRAC_BITS)-1:0] job_i,
  ftile_tile_if.source                          tile_o
);
  import ftile_pkg::*;

  localparam int CW = coord_w(GRID_MAX);
  localparam int TW = tpos_w(GRID_MAX, FRAC_BITS);
  localparam int MW = mag_w(FRAC_BITS);
  localparam int SH = FRAC_BITS + 1;
  localparam int EW = (DBL_W > CW + FRAC_BITS + 3) ? DBL_W : CW + FRAC_BITS + 3;
  localparam logic signed [EW-1:0] ONE_E = EW'(1) << FRAC_BITS;

  typedef struct packed {
    logic                    rect;
    logic [ID_W-1:0]         id;
    logic signed [DBL_W-1:0] c2x;
    logic signed [DBL_W-1:0] c2y;
    logic [CW-1:0]           xs;
    logic [CW-1:0]           xe;
    logic [CW-1:0]           ys;
    logic [CW-1:0]           ye;
    logic signed [TW-1:0]    rx;
    logic signed [TW-1:0]    ry;
    logic [2*MW-1:0]         r2;
  } job_t;

  // distance from a center to the closest point of a tile edge interval
  function automatic logic [MW-1:0] gap(input logic signed [EW-1:0] c,
                                        input logic signed [EW-1:0] lo,
                                        input logic signed [EW-1:0] hi);
    logic [MW-1:0] r;
    if (c < lo) begin
      r = MW'(lo - c);
    end else if (c > hi) begin
      r = MW'(c - hi);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  job_t job;
  assign job = job_i;

  // scan stage
  logic          run_q, run_d;
  logic [CW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [CW-1:0] cur_x, cur_y;
  logic          cand_fire, cand_last, cand_ctr;
  logic signed [EW-1:0] c2x_e, c2y_e, sminx, smaxx, sminy, smaxy;
  logic [MW-1:0] cand_dx, cand_dy;

  // test stage
  logic            tv_q, tv_d;
  logic [CW-1:0]   t_x_q, t_y_q;
  logic [ID_W-1:0] t_id_q;
  logic            t_rect_q, t_ctr_q, t_last_q;
  logic [MW-1:0]   t_dx_q, t_dy_q;
  logic [2*MW-1:0] t_r2_q;
  logic [2*MW:0]   t_dsum;
  logic            t_hit, t_fire, t_free;

  // held hit and output word
  logic            hv_q, hv_d, h_final_q, h_final_d;
  logic [CW-1:0]   h_x_q, h_y_q;
  logic [ID_W-1:0] h_id_q;
  logic            h_cg_q;
  logic            held_move, held_load;
  logic            ov_q, ov_d;
  logic [CW-1:0]   o_x_q, o_y_q;
  logic [ID_W-1:0] o_id_q;
  logic            o_cg_q, o_last_q;
  logic            out_free;

  // candidate tile and its circle gaps
  assign cur_x     = run_q ? sx_q : job.xs;
  assign cur_y     = run_q ? sy_q : job.ys;
  assign cand_last = (cur_x == job.xe) && (cur_y == job.ye);
  assign cand_fire = job_valid_i && t_free;
  assign job_ready_o = cand_fire && cand_last;

  assign c2x_e = EW'($signed(job.c2x));
  assign c2y_e = EW'($signed(job.c2y));
  assign sminx = (EW'(cur_x) << SH) - ONE_E;
  assign smaxx = (EW'(cur_x) << SH) + ONE_E;
  assign sminy = (EW'(cur_y) << SH) - ONE_E;
  assign smaxy = (EW'(cur_y) << SH) + ONE_E;
  assign cand_dx  = gap(c2x_e, sminx, smaxx);
  assign cand_dy  = gap(c2y_e, sminy, smaxy);
  assign cand_ctr = (TW'(cur_x) == job.rx) && (TW'(cur_y) == job.ry);

  // row-order walk over the box
  always_comb begin
    run_d = run_q;
    sx_d  = sx_q;
    sy_d  = sy_q;
    if (cand_fire) begin
      if (cand_last) begin
        run_d = 1'b0;
      end else begin
        run_d = 1'b1;
        if (cur_x == job.xe) begin
          sx_d = job.xs;
          sy_d = cur_y + CW'(1);
        end else begin
          sx_d = cur_x + CW'(1);
          sy_d = cur_y;
        end
      end
    end
  end

  // hit test: every box tile touches a rectangle; a circle needs the distance
  assign t_dsum = (2 * MW + 1)'(t_dx_q) * (2 * MW + 1)'(t_dx_q)
                + (2 * MW + 1)'(t_dy_q) * (2 * MW + 1)'(t_dy_q);
  assign t_hit  = t_rect_q || (t_dsum <= (2 * MW + 1)'(t_r2_q));

  // held hit leaves when the next hit arrives or its job has ended
  assign out_free  = !ov_q || tile_o.ready;
  assign held_move = hv_q && out_free && (h_final_q || (tv_q && t_hit));
  assign t_fire    = tv_q && (!t_hit || !hv_q || held_move);
  assign t_free    = !tv_q || t_fire;
  assign held_load = t_fire && t_hit;

  always_comb begin
    tv_d = tv_q;
    if (t_free) begin
      tv_d = cand_fire;
    end
  end

  always_comb begin
    hv_d      = hv_q;
    h_final_d = h_final_q;
    if (held_load) begin
      hv_d      = 1'b1;
      h_final_d = t_last_q;
    end else if (held_move) begin
      hv_d      = 1'b0;
    end else if (t_fire && t_last_q && hv_q && !h_final_q) begin
      h_final_d = 1'b1;
    end
  end

  always_comb begin
    ov_d = ov_q;
    if (held_move) begin
      ov_d = 1'b1;
    end else if (tile_o.ready) begin
      ov_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      tv_q      <= 1'b0;
      hv_q      <= 1'b0;
      h_final_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      run_q     <= run_d;
      tv_q      <= tv_d;
      hv_q      <= hv_d;
      h_final_q <= h_final_d;
      ov_q      <= ov_d;
    end
  end

  // scan position and data registers
  always_ff @(posedge clk_i) begin
    sx_q <= sx_d;
    sy_q <= sy_d;
    if (cand_fire) begin
      t_x_q    <= cur_x;
      t_y_q    <= cur_y;
      t_id_q   <= job.id;
      t_rect_q <= job.rect;
      t_ctr_q  <= cand_ctr;
      t_last_q <= cand_last;
      t_dx_q   <= cand_dx;
      t_dy_q   <= cand_dy;
      t_r2_q   <= job.r2;
    end
    if (held_load) begin
      h_x_q  <= t_x_q;
      h_y_q  <= t_y_q;
      h_id_q <= t_id_q;
      h_cg_q <= t_rect_q || t_ctr_q;
    end
    if (held_move) begin
      o_x_q    <= h_x_q;
      o_y_q    <= h_y_q;
      o_id_q   <= h_id_q;
      o_cg_q   <= h_cg_q;
      o_last_q <= h_final_q;
    end
  end

  // output word
  assign tile_o.valid          = ov_q;
  assign tile_o.tile_x         = TILE_W'(o_x_q);
  assign tile_o.tile_y         = TILE_W'(o_y_q);
  assign tile_o.owner_id       = o_id_q;
  assign tile_o.in_occupation  = 1'b1;
  assign tile_o.in_center_grid = o_cg_q;
  assign tile_o.last_tile      = o_last_q;

  `FTE_ASSERT_IMP(a_rect_always_hits, tv_q && t_rect_q, t_hit, "rectangle box tile missed")
  `FTE_ASSERT_IMP(a_scan_in_box, run_q, job_valid_i && sx_q <= job.xe && sy_q <= job.ye,
                  "scan position outside job box")
  `FTE_ASSERT_NEXT(a_final_held, hv_q && h_final_q && !out_free, hv_q && h_final_q,
                   "final held word lost under stall")

endmodule
